### design/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg: shared types, codes and tables of the palette color effect unit.
// Holds the effect codes, register indexes, pipeline payload structs and the
// constant tables for the pulse wave and the strobe reciprocals.
// ----------------------------------------------------------------------------
package pce_pkg;

	typedef enum logic [3:0] {
		KIND_FLASH    = 4'd0,
		KIND_FADE_OUT = 4'd1,
		KIND_FADE_IN  = 4'd2,
		KIND_PULSE    = 4'd3,
		KIND_INVERT   = 4'd4,
		KIND_TINT     = 4'd5,
		KIND_DESAT    = 4'd6,
		KIND_STROBE   = 4'd7,
		KIND_HIT      = 4'd8
	} effect_kind_t;

	typedef enum logic [2:0] {
		REG_KIND      = 3'd0,
		REG_INTENSITY = 3'd1,
		REG_SECONDARY = 3'd2,
		REG_COLOR     = 3'd3,
		REG_MASK      = 3'd4,
		REG_ATTACK    = 3'd5,
		REG_HOLD      = 3'd6,
		REG_RELEASE   = 3'd7
	} cfg_reg_t;

	localparam logic [8:0] WHITE = 9'h1FF;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  intensity;
		logic [3:0]  secondary;
		logic [8:0]  effect_color;
		logic [7:0]  group_mask;
		logic [15:0] attack;
		logic [15:0] hold;
		logic [15:0] rel;
	} cfg_t;

	// One weight lane: either a fixed weight or a 4-bit quotient rem/den.
	typedef struct packed {
		logic        use_div;
		logic [3:0]  fixed;
		logic [19:0] rem;
		logic [15:0] den;
		logic [3:0]  q;
	} lane_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       en;
		logic [8:0] cur;
		logic [8:0] base;
		logic       strobe_odd;
		logic [3:0] pw;
		logic       hit;
		logic [3:0] hit_t;
	} item_t;

	// Pulse wave, already scaled to -7..7 and offset by 7.
	localparam logic [3:0] PULSE_TAB [64] = '{
		4'd7, 4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
		4'd11, 4'd12, 4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd14,
		4'd14, 4'd14, 4'd13, 4'd13, 4'd13, 4'd13, 4'd12, 4'd12,
		4'd11, 4'd11, 4'd10, 4'd10, 4'd9, 4'd9, 4'd8, 4'd7,
		4'd7, 4'd7, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4, 4'd3,
		4'd3, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
		4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
		4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7
	};

	// ceil(2^21 / (17 - secondary)); bit 21 of age times this is the parity
	// of the strobe period count.
	localparam logic [20:0] STROBE_RECIP [16] = '{
		21'd123362, 21'd131072, 21'd139811, 21'd149797,
		21'd161320, 21'd174763, 21'd190651, 21'd209716,
		21'd233017, 21'd262144, 21'd299594, 21'd349526,
		21'd419431, 21'd524288, 21'd699051, 21'd1048576
	};

	// One channel blend: (ca*(15-t) + cb*t + 7) / 15, the divide done as a
	// reciprocal multiply that is exact for sums up to 112.
	function automatic logic [2:0] blend_ch(logic [2:0] ca, logic [2:0] cb, logic [3:0] t);
		logic [6:0]  x;
		logic [14:0] p;
		x = 7'(ca) * (7'd15 - 7'(t)) + 7'(cb) * 7'(t) + 7'd7;
		p = 15'(x) * 15'd137;
		return p[13:11];
	endfunction

endpackage

### design/pce_ifs.sv
// ----------------------------------------------------------------------------
// pce_ifs: channel interfaces of the palette color effect unit.
// Input entries, recolored results and the register write channel.
// ----------------------------------------------------------------------------
interface pce_in_if;
	logic        valid;
	logic        ready;
	logic [6:0]  color_index;
	logic [8:0]  base_color;
	logic [8:0]  current_color;
	logic [15:0] age;
	logic [15:0] duration;
	modport source(output valid, color_index, base_color, current_color, age, duration,
		input ready);
	modport sink(input valid, color_index, base_color, current_color, age, duration,
		output ready);
endinterface

interface pce_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] new_color;
	modport source(output valid, new_color, input ready);
	modport sink(input valid, new_color, output ready);
endinterface

interface pce_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/pce_prep.sv
// ----------------------------------------------------------------------------
// pce_prep: first pipeline stage.
// Decodes the envelope and ramp phases into divider lanes and computes the
// group enable, strobe parity, pulse weight and hit flash weight.
// ----------------------------------------------------------------------------
module pce_prep (
	input  logic           clk,
	input  logic           arst_n,
	input  pce_pkg::cfg_t  cfg,
	input  logic           in_valid,
	input  logic [6:0]     color_index,
	input  logic [8:0]     base_color,
	input  logic [8:0]     current_color,
	input  logic [15:0]    age,
	input  logic [15:0]    duration,
	input  logic           ld,
	output logic           v_s1,
	output pce_pkg::item_t item_s1,
	output pce_pkg::lane_t env_s1,
	output pce_pkg::lane_t eff_s1
);
	logic [19:0] age15, rd15, ta15;
	logic [16:0] sum_ah;
	logic [17:0] sum_ahr;
	logic [15:0] d, rd, tot, half, ta;
	logic [2:0]  pk;
	logic [8:0]  phm;
	logic [36:0] sprod;
	pce_pkg::lane_t env_d, eff_d;
	pce_pkg::item_t item_d;

	always_comb begin
		age15   = {age, 4'b0} - {4'b0, age};
		sum_ah  = {1'b0, cfg.attack} + {1'b0, cfg.hold};
		sum_ahr = {1'b0, sum_ah} + {2'b0, cfg.rel};
		d       = age - sum_ah[15:0];
		rd      = cfg.rel - d;
		rd15    = {rd, 4'b0} - {4'b0, rd};
		tot     = (duration == 16'd0) ? 16'd1 : duration;
		half    = 16'(({1'b0, tot} + 17'd1) >> 1);
		ta      = tot - age;
		ta15    = {ta, 4'b0} - {4'b0, ta};

		env_d = '0;
		if ((cfg.attack | cfg.hold | cfg.rel) == 16'd0) begin
			env_d.fixed = 4'd15;
		end else if (age < cfg.attack) begin
			env_d.use_div = 1'b1;
			env_d.rem     = age15;
			env_d.den     = cfg.attack;
		end else if ({1'b0, age} < sum_ah) begin
			env_d.fixed = 4'd15;
		end else if ({2'b0, age} < sum_ahr) begin
			env_d.use_div = 1'b1;
			env_d.rem     = rd15;
			env_d.den     = cfg.rel;
		end

		eff_d = '0;
		case (pce_pkg::effect_kind_t'(cfg.kind))
			pce_pkg::KIND_FLASH: begin
				if (age < half) begin
					eff_d.use_div = 1'b1;
					eff_d.rem     = age15;
					eff_d.den     = half;
				end else if (age < tot) begin
					eff_d.use_div = 1'b1;
					eff_d.rem     = ta15;
					eff_d.den     = half;
				end
			end
			pce_pkg::KIND_FADE_OUT, pce_pkg::KIND_FADE_IN: begin
				if (age15 >= {tot, 4'b0}) begin
					eff_d.fixed = 4'd15;
				end else begin
					eff_d.use_div = 1'b1;
					eff_d.rem     = age15;
					eff_d.den     = tot;
				end
			end
			default: eff_d = '0;
		endcase

		pk    = 3'd1 + {1'b0, cfg.secondary[3:2]};
		phm   = 9'(age[5:0]) * 9'(pk);
		sprod = 37'(age) * 37'(pce_pkg::STROBE_RECIP[cfg.secondary]);

		item_d.kind       = cfg.kind;
		item_d.en         = cfg.group_mask[color_index[6:4]];
		item_d.cur        = current_color;
		item_d.base       = base_color;
		item_d.strobe_odd = sprod[21];
		item_d.pw         = pce_pkg::PULSE_TAB[phm[5:0]];
		item_d.hit        = (age < 16'd3);
		item_d.hit_t      = 4'd15 - ({2'b0, age[1:0]} * 4'd5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			item_s1 <= item_d;
			env_s1  <= env_d;
			eff_s1  <= eff_d;
		end
	end
endmodule

### design/pce_div2.sv
// ----------------------------------------------------------------------------
// pce_div2: two restoring division steps on both weight lanes.
// Two instances produce quotient bits 3:2 and 1:0.
// ----------------------------------------------------------------------------
module pce_div2 #(
	parameter int HI_STEP = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_in,
	input  pce_pkg::item_t item_in,
	input  pce_pkg::lane_t env_in,
	input  pce_pkg::lane_t eff_in,
	input  logic           ld,
	output logic           v_out,
	output pce_pkg::item_t item_out,
	output pce_pkg::lane_t env_out,
	output pce_pkg::lane_t eff_out
);
	localparam int LO_STEP = HI_STEP - 1;

	function automatic pce_pkg::lane_t two_steps(pce_pkg::lane_t l);
		pce_pkg::lane_t o;
		logic [20:0] dh, dl;
		o  = l;
		dh = 21'(l.den) << HI_STEP;
		dl = 21'(l.den) << LO_STEP;
		if ({1'b0, o.rem} >= dh) begin
			o.rem        = o.rem - dh[19:0];
			o.q[HI_STEP] = 1'b1;
		end
		if ({1'b0, o.rem} >= dl) begin
			o.rem        = o.rem - dl[19:0];
			o.q[LO_STEP] = 1'b1;
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (ld) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			item_out <= item_in;
			env_out  <= two_steps(env_in);
			eff_out  <= two_steps(eff_in);
		end
	end
endmodule

### design/pce_mix.sv
// ----------------------------------------------------------------------------
// pce_mix: weight selection and channel blend, the last two stages.
// Picks target color and weight for the effect, then blends per channel.
// ----------------------------------------------------------------------------
module pce_mix (
	input  logic           clk,
	input  logic           arst_n,
	input  pce_pkg::cfg_t  cfg,
	input  logic           v_in,
	input  pce_pkg::item_t item_in,
	input  pce_pkg::lane_t env_in,
	input  pce_pkg::lane_t eff_in,
	input  logic           ld4,
	input  logic           ld5,
	output logic           v_s4,
	output logic           v_s5,
	output logic [8:0]     new_color_s5
);
	logic [3:0]  env, eff, amp, tp, t_d;
	logic [7:0]  ip, xp;
	logic [14:0] ap;
	logic [13:0] tpp;
	logic [4:0]  gs;
	logic [7:0]  gp;
	logic [8:0]  gray, a_d, b_d;
	logic        pass_d;
	logic [8:0]  a_s4, b_s4, blended;
	logic [3:0]  t_s4;
	logic        pass_s4;

	always_comb begin
		env = env_in.use_div ? env_in.q : env_in.fixed;
		eff = eff_in.use_div ? eff_in.q : eff_in.fixed;
		ip  = 8'(cfg.intensity) * 8'(env);
		ap  = 15'(ip) * 15'd137;
		amp = ap[14:11];
		xp  = 8'(item_in.pw) * 8'(cfg.intensity);
		tpp = 14'(xp[7:1]) * 14'd147;
		tp  = tpp[13:10];
		gs  = 5'(item_in.base[8:6]) + 5'(item_in.base[5:3]) + 5'(item_in.base[2:0]) + 5'd1;
		gp  = 8'(gs) * 8'd11;
		gray = {gp[7:5], gp[7:5], gp[7:5]};

		a_d    = item_in.cur;
		b_d    = item_in.cur;
		t_d    = 4'd0;
		pass_d = 1'b0;
		unique case (pce_pkg::effect_kind_t'(item_in.kind))
			pce_pkg::KIND_FLASH: begin
				b_d = cfg.effect_color;
				t_d = eff;
			end
			pce_pkg::KIND_FADE_OUT: begin
				b_d = 9'd0;
				t_d = eff;
			end
			pce_pkg::KIND_FADE_IN: begin
				a_d = 9'd0;
				b_d = item_in.base;
				t_d = eff;
			end
			pce_pkg::KIND_PULSE: begin
				b_d = pce_pkg::WHITE;
				t_d = tp;
			end
			pce_pkg::KIND_INVERT: begin
				b_d = ~item_in.base;
				t_d = amp;
			end
			pce_pkg::KIND_TINT: begin
				b_d = cfg.effect_color;
				t_d = amp;
			end
			pce_pkg::KIND_DESAT: begin
				b_d = gray;
				t_d = amp;
			end
			pce_pkg::KIND_STROBE: begin
				b_d    = cfg.effect_color;
				t_d    = amp;
				pass_d = !item_in.strobe_odd;
			end
			pce_pkg::KIND_HIT: begin
				b_d    = pce_pkg::WHITE;
				t_d    = item_in.hit_t;
				pass_d = !item_in.hit;
			end
			default: pass_d = 1'b1;
		endcase
		if (!item_in.en) begin
			a_d    = item_in.cur;
			pass_d = 1'b1;
		end
	end

	always_comb begin
		blended = {pce_pkg::blend_ch(a_s4[8:6], b_s4[8:6], t_s4),
			pce_pkg::blend_ch(a_s4[5:3], b_s4[5:3], t_s4),
			pce_pkg::blend_ch(a_s4[2:0], b_s4[2:0], t_s4)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld4) begin
				v_s4 <= v_in;
			end
			if (ld5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			a_s4    <= a_d;
			b_s4    <= b_d;
			t_s4    <= t_d;
			pass_s4 <= pass_d;
		end
		if (ld5) begin
			new_color_s5 <= pass_s4 ? a_s4 : blended;
		end
	end
endmodule

### design/palette_color_effect_unit.sv
// ----------------------------------------------------------------------------
// palette_color_effect_unit: recolors RGB333 palette entries for one frame.
// Five-stage pipeline computing flash, fade, pulse, invert, tint, desaturate,
// strobe and hit flash effects on a stream of palette entries.
// ----------------------------------------------------------------------------
// Usage: entries arrive as beats on item_in (index, base color, current color,
// age, duration) and leave as beats on item_out carrying new_color, one result
// beat per input beat and in the same order. Registers are written through
// cfg, one beat per register; cfg is always ready and should be written only
// while no entry is in flight.
// Throughput is one beat per cycle while the receiver is ready: stage 1
// decodes the envelope and ramp phases, stages 2 and 3 each resolve two
// quotient bits of the 4-bit weight divisions, stage 4 scales and selects
// the weight and target, and stage 5 blends the three channels into the
// output register.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves, so a stalled receiver holds the output beat while
// bubbles in earlier stages keep filling; nothing is dropped or repeated.
// Reset clears all valid bits and returns the registers to their defaults
// (flash, full intensity, white target, all groups, no envelope).
// ----------------------------------------------------------------------------
module palette_color_effect_unit (
	input  logic     clk,
	input  logic     arst_n,
	pce_cfg_if.sink  cfg,
	pce_in_if.sink   item_in,
	pce_out_if.source item_out
);
	pce_pkg::cfg_t  cfg_q;
	logic           v_s1, v_s2, v_s3, v_s4, v_s5;
	logic           rdy1, rdy2, rdy3, rdy4, rdy5;
	pce_pkg::item_t item_s1, item_s2, item_s3;
	pce_pkg::lane_t env_s1, env_s2, env_s3, eff_s1, eff_s2, eff_s3;
	logic [8:0]     new_color_s5;

	// Register file. Writes are taken every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind         <= 4'd0;
			cfg_q.intensity    <= 4'd15;
			cfg_q.secondary    <= 4'd0;
			cfg_q.effect_color <= 9'h1FF;
			cfg_q.group_mask   <= 8'hFF;
			cfg_q.attack       <= 16'd0;
			cfg_q.hold         <= 16'd0;
			cfg_q.rel          <= 16'd0;
		end else if (cfg.valid) begin
			unique case (pce_pkg::cfg_reg_t'(cfg.index))
				pce_pkg::REG_KIND:      cfg_q.kind         <= cfg.data[3:0];
				pce_pkg::REG_INTENSITY: cfg_q.intensity    <= cfg.data[3:0];
				pce_pkg::REG_SECONDARY: cfg_q.secondary    <= cfg.data[3:0];
				pce_pkg::REG_COLOR:     cfg_q.effect_color <= cfg.data[8:0];
				pce_pkg::REG_MASK:      cfg_q.group_mask   <= cfg.data[7:0];
				pce_pkg::REG_ATTACK:    cfg_q.attack       <= cfg.data;
				pce_pkg::REG_HOLD:      cfg_q.hold         <= cfg.data;
				pce_pkg::REG_RELEASE:   cfg_q.rel          <= cfg.data;
				default: ;
			endcase
		end
	end

	// Backpressure: a stage loads when it is empty or its successor moves.
	assign rdy5 = !v_s5 || item_out.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign item_in.ready = rdy1;

	pce_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (item_in.valid),
		.color_index   (item_in.color_index),
		.base_color    (item_in.base_color),
		.current_color (item_in.current_color),
		.age           (item_in.age),
		.duration      (item_in.duration),
		.ld            (rdy1),
		.v_s1          (v_s1),
		.item_s1       (item_s1),
		.env_s1        (env_s1),
		.eff_s1        (eff_s1)
	);

	// Quotient bits 3 and 2.
	pce_div2 #(.HI_STEP(3)) u_div_hi (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v_s1),
		.item_in  (item_s1),
		.env_in   (env_s1),
		.eff_in   (eff_s1),
		.ld       (rdy2),
		.v_out    (v_s2),
		.item_out (item_s2),
		.env_out  (env_s2),
		.eff_out  (eff_s2)
	);

	// Quotient bits 1 and 0.
	pce_div2 #(.HI_STEP(1)) u_div_lo (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v_s2),
		.item_in  (item_s2),
		.env_in   (env_s2),
		.eff_in   (eff_s2),
		.ld       (rdy3),
		.v_out    (v_s3),
		.item_out (item_s3),
		.env_out  (env_s3),
		.eff_out  (eff_s3)
	);

	pce_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.v_in         (v_s3),
		.item_in      (item_s3),
		.env_in       (env_s3),
		.eff_in       (eff_s3),
		.ld4          (rdy4),
		.ld5          (rdy5),
		.v_s4         (v_s4),
		.v_s5         (v_s5),
		.new_color_s5 (new_color_s5)
	);

	assign item_out.valid     = v_s5;
	assign item_out.new_color = new_color_s5;

	// An accepted input beat always lands in stage 1.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	// Division lanes only ever need a 4-bit quotient.
	a_env_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && env_s1.use_div |-> ({1'b0, env_s1.rem} < {1'b0, env_s1.den, 4'b0}))
		else $error("envelope quotient exceeds 4 bits");

	a_eff_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && eff_s1.use_div |-> ({1'b0, eff_s1.rem} < {1'b0, eff_s1.den, 4'b0}))
		else $error("ramp quotient exceeds 4 bits");

	// A stalled output beat stays valid until the receiver takes it.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !item_out.ready |=> v_s5)
		else $error("output beat lost during stall");
endmodule
